@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the tile deduplication RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked out of reset only.
`define TDI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define TDI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TDI_ASSERT(lbl, prop, msg)
`define TDI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/tdi_pkg.sv @@
// Package with constants, types and state encoding of the tile deduplication indexer.
package tdi_pkg;

  localparam int DEF_MAX_TILES       = 1024;
  localparam int DEF_MAX_TILE_PIXELS = 64;
  localparam int DEF_PIXEL_BITS      = 8;

  localparam int PIXEL_W = 8;
  localparam int CFG_W   = 7;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  localparam logic [CFG_W-1:0] TILE_PIXELS_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_GATHER,
    ST_SEARCH,
    ST_HOLD
  } tdi_state_t;

  // Control from the gather logic to the tile store.
  typedef struct packed {
    logic pix_wr;
    logic slot_wr;
    logic start;
  } tdi_ctl_t;

  // Search status from the tile store.
  typedef struct packed {
    logic done;
    logic found;
  } tdi_rsp_t;

endpackage

@@ rtl/core/tdi_store.sv @@
// Tile store and incoming tile memories with the sequential match search.
`include "assert_macros.svh"

module tdi_store import tdi_pkg::*; #(
  parameter int MAX_TILES       = DEF_MAX_TILES,
  parameter int MAX_TILE_PIXELS = DEF_MAX_TILE_PIXELS,
  parameter int PIXEL_BITS      = DEF_PIXEL_BITS,
  localparam int TI_W  = $clog2(MAX_TILES),
  localparam int CNT_W = $clog2(MAX_TILES + 1),
  localparam int PA_W  = (MAX_TILE_PIXELS > 1) ? $clog2(MAX_TILE_PIXELS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tdi_ctl_t              ctl,
  input  logic [PA_W-1:0]       wr_pos,
  input  logic [PIXEL_BITS-1:0] wr_pixel,
  input  logic [TI_W-1:0]       wr_slot,
  input  logic [CNT_W-1:0]      count,
  input  logic [PA_W-1:0]       last_pos,
  output tdi_rsp_t              rsp,
  output logic [TI_W-1:0]       rsp_index
);

  localparam int STORE_DEPTH = MAX_TILES * (2 ** PA_W);

  logic [PIXEL_BITS-1:0] store_mem [0:STORE_DEPTH-1];
  logic [PIXEL_BITS-1:0] inc_mem   [0:MAX_TILE_PIXELS-1];

  logic                  act_r, act_nxt;
  logic [CNT_W-1:0]      iss_t_r, iss_t_nxt;
  logic [PA_W-1:0]       iss_p_r, iss_p_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [TI_W-1:0]       cmp_t_r, cmp_t_nxt;
  logic                  cmp_last_r, cmp_last_nxt;
  logic [PIXEL_BITS-1:0] store_q_r;
  logic [PIXEL_BITS-1:0] inc_q_r;
  logic                  iss_ok;
  logic                  mism;
  logic                  hit;

  assign iss_ok = act_r && (iss_t_r < count);
  assign mism   = cmp_vld_r && (store_q_r != inc_q_r);
  assign hit    = cmp_vld_r && !mism && cmp_last_r;

  // One read of the store per cycle; a mismatch squashes the read in flight
  // and restarts at pixel zero of the next stored tile.
  always_comb begin
    act_nxt      = act_r;
    iss_t_nxt    = iss_t_r;
    iss_p_nxt    = iss_p_r;
    cmp_vld_nxt  = 1'b0;
    cmp_t_nxt    = cmp_t_r;
    cmp_last_nxt = cmp_last_r;
    rsp          = '0;
    rsp_index    = cmp_t_r;
    if (!act_r) begin
      if (ctl.start) begin
        act_nxt   = 1'b1;
        iss_t_nxt = '0;
        iss_p_nxt = '0;
      end
    end else if (hit) begin
      act_nxt   = 1'b0;
      rsp.done  = 1'b1;
      rsp.found = 1'b1;
    end else if (mism) begin
      iss_t_nxt = CNT_W'(cmp_t_r) + CNT_W'(1);
      iss_p_nxt = '0;
    end else if (iss_ok) begin
      cmp_vld_nxt  = 1'b1;
      cmp_t_nxt    = iss_t_r[TI_W-1:0];
      cmp_last_nxt = (iss_p_r == last_pos);
      if (iss_p_r == last_pos) begin
        iss_t_nxt = iss_t_r + CNT_W'(1);
        iss_p_nxt = '0;
      end else begin
        iss_p_nxt = iss_p_r + PA_W'(1);
      end
    end else if (!cmp_vld_r) begin
      act_nxt  = 1'b0;
      rsp.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
    iss_t_r    <= iss_t_nxt;
    iss_p_r    <= iss_p_nxt;
    cmp_t_r    <= cmp_t_nxt;
    cmp_last_r <= cmp_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.slot_wr) begin
      store_mem[{wr_slot, wr_pos}] <= wr_pixel;
    end
    store_q_r <= store_mem[{iss_t_r[TI_W-1:0], iss_p_r}];
  end

  always_ff @(posedge clk) begin
    if (ctl.pix_wr) begin
      inc_mem[wr_pos] <= wr_pixel;
    end
    inc_q_r <= inc_mem[iss_p_r];
  end

  `TDI_ASSERT(a_cmp_needs_act, cmp_vld_r |-> act_r, "compare stage valid while search idle")
  `TDI_ASSERT(a_start_idle, ctl.start |-> !act_r, "search started while one is running")
  `TDI_ASSERT(a_hit_in_range, (rsp.done && rsp.found) |-> ({1'b0, rsp_index} < count),
    "match reported beyond the stored tiles")

endmodule

@@ rtl/core/tile_dedup_indexer.sv @@
// Top level of the tile deduplication indexer: pixel gathering, configuration and result register.
`include "assert_macros.svh"

// Pixels of a tile are taken one per cycle while the block is gathering and no
// configuration request is pending, and are written straight into the incoming
// tile buffer and, while the list has room, into the next free slot of the tile
// store. After the last pixel the store is searched with one memory read per
// cycle; a differing pixel ends the compare of a stored tile and the search goes
// on at the first pixel of the next one. A full match or the end of the list ends
// the search, and the result then moves to the output register through the hold
// state, which waits while the previous result is still held there. The tile
// store has a single read port. Writing tile_pixels empties the store and
// restarts the current tile; a pending configuration request holds off the pixel
// input.
module tile_dedup_indexer import tdi_pkg::*; #(
  parameter int MAX_TILES       = DEF_MAX_TILES,
  parameter int MAX_TILE_PIXELS = DEF_MAX_TILE_PIXELS,
  parameter int PIXEL_BITS      = DEF_PIXEL_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIXEL_W-1:0] in_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] out_tile_index,
  output logic               out_is_new,
  output logic               out_table_full,
  output logic [COUNT_W-1:0] out_unique_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int TI_W  = $clog2(MAX_TILES);
  localparam int CNT_W = $clog2(MAX_TILES + 1);
  localparam int PA_W  = (MAX_TILE_PIXELS > 1) ? $clog2(MAX_TILE_PIXELS) : 1;
  localparam int RESET_SIZE = (MAX_TILE_PIXELS < 64) ? MAX_TILE_PIXELS : 64;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TILES);
  localparam logic [8:0]       MTP9    = 9'(MAX_TILE_PIXELS);

  tdi_state_t state_r, state_nxt;

  logic [PA_W-1:0]    pos_r, pos_nxt;
  logic [PA_W-1:0]    last_pos_r, last_pos_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TI_W-1:0]    res_idx_r, res_idx_nxt;
  logic               res_new_r, res_new_nxt;
  logic               res_full_r, res_full_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic               out_new_r, out_new_nxt;
  logic               out_full_r, out_full_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  tdi_ctl_t        ctl;
  tdi_rsp_t        rsp;
  logic [TI_W-1:0] rsp_index;
  logic            in_acc;
  logic            cfg_acc;

  // A size of zero acts as one pixel, a size above the buffer as a full buffer.
  function automatic logic [PA_W-1:0] last_of(input logic [CFG_W-1:0] tp);
    logic [8:0] tp9;
    tp9 = 9'(tp);
    if (tp9 == 9'd0) begin
      last_of = '0;
    end else if (tp9 > MTP9) begin
      last_of = PA_W'(MTP9 - 9'd1);
    end else begin
      last_of = PA_W'(tp9 - 9'd1);
    end
  endfunction

  // A configuration request takes the edge first; the pixel waits while it is pending.
  assign in_ready  = (state_r == ST_GATHER) && !cfg_valid;
  assign cfg_ready = (state_r == ST_GATHER);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    last_pos_nxt  = last_pos_r;
    count_nxt     = count_r;
    res_idx_nxt   = res_idx_r;
    res_new_nxt   = res_new_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    out_cnt_nxt   = out_cnt_r;
    ctl           = '0;
    case (state_r)
      ST_GATHER: begin
        if (in_acc) begin
          ctl.pix_wr  = 1'b1;
          ctl.slot_wr = (count_r < CNT_MAX);
          if (pos_r == last_pos_r) begin
            pos_nxt   = '0;
            ctl.start = 1'b1;
            state_nxt = ST_SEARCH;
          end else begin
            pos_nxt = pos_r + PA_W'(1);
          end
        end
      end
      ST_SEARCH: begin
        if (rsp.done) begin
          state_nxt    = ST_HOLD;
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          if (rsp.found) begin
            res_idx_nxt = rsp_index;
          end else if (count_r < CNT_MAX) begin
            // The tile already sits in slot count_r; appending only bumps the count.
            res_idx_nxt = count_r[TI_W-1:0];
            res_new_nxt = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
          end else begin
            res_idx_nxt  = '0;
            res_full_nxt = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = INDEX_W'(res_idx_r);
          out_new_nxt   = res_new_r;
          out_full_nxt  = res_full_r;
          out_cnt_nxt   = COUNT_W'(count_r);
          state_nxt     = ST_GATHER;
        end
      end
      default: begin
        state_nxt = ST_GATHER;
      end
    endcase
    if (cfg_acc) begin
      last_pos_nxt = last_of(cfg_data);
      count_nxt    = '0;
      pos_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_GATHER;
      pos_r       <= '0;
      last_pos_r  <= PA_W'(RESET_SIZE - 1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      last_pos_r  <= last_pos_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_full_r <= out_full_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  tdi_store #(
    .MAX_TILES       (MAX_TILES),
    .MAX_TILE_PIXELS (MAX_TILE_PIXELS),
    .PIXEL_BITS      (PIXEL_BITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wr_pos    (pos_r),
    .wr_pixel  (in_pixel[PIXEL_BITS-1:0]),
    .wr_slot   (count_r[TI_W-1:0]),
    .count     (count_r),
    .last_pos  (last_pos_r),
    .rsp       (rsp),
    .rsp_index (rsp_index)
  );

  assign out_valid        = out_valid_r;
  assign out_tile_index   = out_idx_r;
  assign out_is_new       = out_new_r;
  assign out_table_full   = out_full_r;
  assign out_unique_count = out_cnt_r;

  `TDI_ASSERT(a_done_in_search, rsp.done |-> (state_r == ST_SEARCH),
    "search finished outside the search state")
  `TDI_ASSERT(a_new_not_full, out_valid_r |-> !(out_new_r && out_full_r),
    "result both new and full")
  `TDI_ASSERT(a_count_grows_on_new,
    (count_r > $past(count_r)) |-> $past(rsp.done && !rsp.found),
    "tile count grew without an append")

endmodule

@@ bench/tile_dedup_indexer_tb.sv @@
// Testbench of the tile deduplication indexer: directed table, then random tile sets.
module tile_dedup_indexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdi_pkg::*;

  localparam int N_TILES         = DEF_MAX_TILES;
  localparam int N_PIX           = DEF_MAX_TILE_PIXELS;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 64;
  localparam int HOLD_AT_VERDICT = 15;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [INDEX_W-1:0] tile_index;
    logic               is_new;
    logic               table_full;
    logic [COUNT_W-1:0] unique_count;
  } tile_verdict_t;

  typedef enum logic {
    ROW_CFG,
    ROW_PIXEL
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [PIXEL_W-1:0] value;
    logic               typed;
    tile_verdict_t      verdict;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIXEL_W-1:0] in_pixel = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [INDEX_W-1:0] out_tile_index;
  logic               out_is_new;
  logic               out_table_full;
  logic [COUNT_W-1:0] out_unique_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;

  // Predictor state: the unique tile list, the tile being gathered and the size register.
  logic [PIXEL_W-1:0] unique_tiles [N_TILES][N_PIX];
  logic [PIXEL_W-1:0] gather_buf [N_PIX];
  int unsigned        unique_total = 0;
  int unsigned        gather_pos = 0;
  logic [CFG_W-1:0]   tile_pixels_reg = TILE_PIXELS_RESET;

  tile_verdict_t      pending_verdicts [$];
  logic [PIXEL_W-1:0] tile_buf [N_PIX];
  int unsigned        error_count = 0;
  int unsigned        verdicts_seen = 0;
  int unsigned        burst_left = 0;

  // The size register is written with a partial tile pending, which must be dropped.
  stim_row_t directed_rows [22] = '{
    '{ROW_CFG,   8'd1,  1'b0, '0},
    '{ROW_PIXEL, 8'h00, 1'b1, '{10'd0, 1'b1, 1'b0, 11'd1}},
    '{ROW_PIXEL, 8'hFF, 1'b1, '{10'd1, 1'b1, 1'b0, 11'd2}},
    '{ROW_PIXEL, 8'h00, 1'b1, '{10'd0, 1'b0, 1'b0, 11'd2}},
    '{ROW_PIXEL, 8'hFF, 1'b1, '{10'd1, 1'b0, 1'b0, 11'd2}},
    '{ROW_CFG,   8'd0,  1'b0, '0},
    '{ROW_PIXEL, 8'hFF, 1'b1, '{10'd0, 1'b1, 1'b0, 11'd1}},
    '{ROW_PIXEL, 8'h80, 1'b0, '0},
    '{ROW_PIXEL, 8'hFF, 1'b1, '{10'd0, 1'b0, 1'b0, 11'd2}},
    '{ROW_CFG,   8'd3,  1'b0, '0},
    '{ROW_PIXEL, 8'h01, 1'b0, '0},
    '{ROW_PIXEL, 8'h02, 1'b0, '0},
    '{ROW_CFG,   8'd3,  1'b0, '0},
    '{ROW_PIXEL, 8'h01, 1'b0, '0},
    '{ROW_PIXEL, 8'h02, 1'b0, '0},
    '{ROW_PIXEL, 8'h03, 1'b1, '{10'd0, 1'b1, 1'b0, 11'd1}},
    '{ROW_PIXEL, 8'h01, 1'b0, '0},
    '{ROW_PIXEL, 8'h02, 1'b0, '0},
    '{ROW_PIXEL, 8'h04, 1'b1, '{10'd1, 1'b1, 1'b0, 11'd2}},
    '{ROW_PIXEL, 8'h01, 1'b0, '0},
    '{ROW_PIXEL, 8'h02, 1'b0, '0},
    '{ROW_PIXEL, 8'h03, 1'b1, '{10'd0, 1'b0, 1'b0, 11'd2}}
  };

  tile_dedup_indexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tile_index   (out_tile_index),
    .out_is_new       (out_is_new),
    .out_table_full   (out_table_full),
    .out_unique_count (out_unique_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned active_tile_size();
    if (tile_pixels_reg == 0) return 1;
    if (tile_pixels_reg > N_PIX) return N_PIX;
    return tile_pixels_reg;
  endfunction

  // Takes one pixel; returns 1 with the verdict when it completes a tile.
  function automatic bit dedup_predict(input logic [PIXEL_W-1:0] px,
                                       output tile_verdict_t verdict);
    int unsigned size;
    int unsigned slot;
    int unsigned k;
    bit          same;
    size = active_tile_size();
    verdict = '0;
    if (gather_pos >= size) gather_pos = 0;
    gather_buf[gather_pos] = px;
    gather_pos++;
    if (gather_pos < size) return 1'b0;
    gather_pos = 0;
    for (slot = 0; slot < unique_total; slot++) begin
      same = 1'b1;
      for (k = 0; k < size; k++)
        if (unique_tiles[slot][k] != gather_buf[k]) same = 1'b0;
      if (same) begin
        verdict.tile_index = slot[INDEX_W-1:0];
        verdict.unique_count = unique_total[COUNT_W-1:0];
        return 1'b1;
      end
    end
    if (unique_total >= N_TILES) begin
      verdict.table_full = 1'b1;
    end else begin
      for (k = 0; k < size; k++) unique_tiles[unique_total][k] = gather_buf[k];
      verdict.tile_index = unique_total[INDEX_W-1:0];
      verdict.is_new = 1'b1;
      unique_total++;
    end
    verdict.unique_count = unique_total[COUNT_W-1:0];
    return 1'b1;
  endfunction

  // Fills tile_buf with a fresh tile, a stored tile, or a stored tile with one pixel changed.
  function automatic void build_tile(input int unsigned size, input int unsigned reuse_odds,
                                     input bit biased);
    int unsigned src;
    int unsigned k;
    if (unique_total != 0 && $urandom_range(reuse_odds - 1, 0) == 0) begin
      src = $urandom_range(unique_total - 1, 0);
      for (k = 0; k < size; k++) tile_buf[k] = unique_tiles[src][k];
      if ($urandom_range(1, 0) == 1) begin
        k = $urandom_range(size - 1, 0);
        tile_buf[k] = tile_buf[k] ^ PIXEL_W'($urandom_range(255, 1));
      end
    end else begin
      for (k = 0; k < size; k++) begin
        case (biased ? $urandom_range(3, 0) : 3)
          0:       tile_buf[k] = '0;
          1:       tile_buf[k] = '1;
          default: tile_buf[k] = PIXEL_W'($urandom);
        endcase
      end
    end
  endfunction

  task automatic offer_pixel(input logic [PIXEL_W-1:0] px, input logic typed,
                             input tile_verdict_t typed_verdict);
    int unsigned   gap;
    tile_verdict_t verdict;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      if ($urandom_range(3, 0) != 0) gap = $urandom_range(8, 1);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    if (dedup_predict(px, verdict))
      pending_verdicts.push_back(typed ? typed_verdict : verdict);
  endtask

  task automatic send_tile(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) offer_pixel(tile_buf[k], 1'b0, '0);
  endtask

  task automatic drain_verdicts(input int unsigned extra);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // A size write clears the unique list and restarts the tile being gathered.
  task automatic write_tile_pixels(input logic [CFG_W-1:0] value);
    drain_verdicts(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tile_pixels_reg = value;
    unique_total = 0;
    gather_pos = 0;
  endtask

  initial begin : stimulus
    int unsigned row;
    int unsigned phase;
    int unsigned n;
    int unsigned size;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (row = 0; row < $size(directed_rows); row++) begin
      if (directed_rows[row].kind == ROW_CFG)
        write_tile_pixels(directed_rows[row].value[CFG_W-1:0]);
      else
        offer_pixel(directed_rows[row].value, directed_rows[row].typed,
                    directed_rows[row].verdict);
    end
    // Small tiles; each set ends with a partial tile that the next size write drops.
    for (phase = 0; phase < 3; phase++) begin
      size = $urandom_range(9, 2);
      write_tile_pixels(CFG_W'(size));
      for (n = 0; n < 10; n++) begin
        build_tile(size, 2, 1'b1);
        send_tile(size);
      end
      build_tile(size, 2, 1'b1);
      send_tile($urandom_range(size - 1, 1));
    end
    write_tile_pixels(7'd64);
    for (n = 0; n < 2; n++) begin
      build_tile(N_PIX, 2, 1'b1);
      send_tile(N_PIX);
    end
    write_tile_pixels(7'd127);
    for (n = 0; n < 1; n++) begin
      build_tile(N_PIX, 2, 1'b1);
      send_tile(N_PIX);
    end
    // Fill the list to its limit with two-pixel tiles, then keep offering past it.
    write_tile_pixels(7'd2);
    while (unique_total < N_TILES) begin
      build_tile(2, 16, 1'b0);
      send_tile(2);
    end
    for (n = 0; n < 8; n++) begin
      build_tile(2, 2, 1'b0);
      send_tile(2);
    end
    drain_verdicts(TAIL_CYCLES);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned   hold_left;
    int unsigned   mode_left;
    int unsigned   mode;
    bit            held;
    tile_verdict_t got;
    tile_verdict_t want;
    hold_left = 0;
    mode_left = 0;
    mode = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{out_tile_index, out_is_new, out_table_full, out_unique_count};
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected tile result: index %0d new %0b full %0b count %0d",
                     got.tile_index, got.is_new, got.table_full, got.unique_count);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.tile_index !== want.tile_index || got.is_new !== want.is_new ||
              got.table_full !== want.table_full || got.unique_count !== want.unique_count) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("tile result %0d: expected index %0d new %0b full %0b count %0d, %s",
                       verdicts_seen, want.tile_index, want.is_new, want.table_full,
                       want.unique_count,
                       $sformatf("got index %0d new %0b full %0b count %0d", got.tile_index,
                                 got.is_new, got.table_full, got.unique_count));
          end
        end
      end
      // One long hold-off lets the block back up into its input.
      if (!held && verdicts_seen == HOLD_AT_VERDICT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(3, 0);
          mode_left = $urandom_range(200, 20);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(1, 0) == 1);
          2:       out_ready <= ($urandom_range(3, 0) == 0);
          default: out_ready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #60ms;
    $display("FAIL");
    $finish;
  end

endmodule
